// ===== rtl/indexed_shift_array_defines.svh =====
// Assertion macros for the indexed shift array.
`ifndef INDEXED_SHIFT_ARRAY_DEFINES_SVH
`define INDEXED_SHIFT_ARRAY_DEFINES_SVH

// Check a consequence in the same cycle as its condition.
`define ISA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its condition.
`define ISA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/isa_pkg.sv =====
package isa_pkg;

   // Operation codes carried in the func field
   localparam logic [2:0] FUNC_READ    = 3'd0;
   localparam logic [2:0] FUNC_INSERT  = 3'd1;
   localparam logic [2:0] FUNC_ERASE   = 3'd2;
   localparam logic [2:0] FUNC_EXTRACT = 3'd3;
   localparam logic [2:0] FUNC_CLEAR   = 3'd4;

   localparam int unsigned IndexW = 5;
   localparam int unsigned DataW  = 32;
   localparam int unsigned CountW = 5;

   typedef struct packed {
      logic [2:0]        func;
      logic [IndexW-1:0] index;
      logic              at_end;
      logic [DataW-1:0]  write_data;
   } isa_req_type;

   typedef struct packed {
      logic              ok;
      logic [DataW-1:0]  read_data;
      logic [CountW-1:0] count;
      logic              empty_res;
   } isa_rsp_type;

   // Broadcast shift command for the cell row
   typedef struct packed {
      logic insert;
      logic remove;
   } isa_cell_ctrl_type;

endpackage

// ===== rtl/isa_cell.sv =====
module isa_cell #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned PW    = 4,
   parameter int unsigned IDX   = 0
) (
   input  logic                       clock,
   input  isa_pkg::isa_cell_ctrl_type ctrl,
   input  logic [PW-1:0]              pos,
   input  logic [WIDTH-1:0]           wdata,
   input  logic [WIDTH-1:0]           left_in,
   input  logic [WIDTH-1:0]           right_in,
   output logic [WIDTH-1:0]           data_out,
   output logic [WIDTH-1:0]           tap_out
);

   logic [WIDTH-1:0] data_ff;
   logic [WIDTH-1:0] data_in;
   logic             at_pos;
   logic             above;

   assign at_pos = (pos == PW'(IDX));
   assign above  = (PW'(IDX) > pos);

   // Take the new word, the lower neighbor on insert, the upper neighbor on removal
   always_comb begin
      data_in = data_ff;
      if (ctrl.insert) begin
         if (at_pos) begin
            data_in = wdata;
         end else if (above) begin
            data_in = left_in;
         end
      end else if (ctrl.remove) begin
         if (at_pos || above) begin
            data_in = right_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   // Drive the word onto the read tree only at the selected position
   assign tap_out  = data_ff & {WIDTH{at_pos}};

endmodule

// ===== rtl/indexed_shift_array.sv =====
// Channel   Ports                          Direction  Beat content
// request   req_valid req_stall req_data   in         one operation
// response  rsp_valid rsp_stall rsp_data   out        one result per request
//
// Each request is decoded and executed in the cycle it is accepted; the result
// is registered and shown from the next cycle, so one request per cycle while
// req_stall is low. All cells shift in parallel in that same cycle; the read
// path is an AND-OR tree over the DEPTH cells. Reset clears the element count
// and the response valid; cell contents need no clearing. req_stall is high
// only while a result waits in the response register under rsp_stall.
`include "indexed_shift_array_defines.svh"

module indexed_shift_array #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  isa_pkg::isa_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output isa_pkg::isa_rsp_type rsp_data
);

   localparam int unsigned PW   = $clog2(DEPTH);
   localparam int unsigned CW   = $clog2(DEPTH + 1);
   localparam int unsigned CMPW = (CW > isa_pkg::IndexW) ? CW : isa_pkg::IndexW;

   logic [CW-1:0]              fill_ff;
   logic [CW-1:0]              fill_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   isa_pkg::isa_rsp_type       rsp_ff;
   isa_pkg::isa_rsp_type       rsp_in;
   logic                       req_acc;
   logic                       op_ok;
   logic                       ins_ok;
   logic                       rd_ok;
   logic [CMPW-1:0]            ins_pos;
   logic [CMPW-1:0]            rd_pos;
   logic [PW-1:0]              cell_pos;
   isa_pkg::isa_cell_ctrl_type cell_ctrl;
   logic [WIDTH-1:0]           wdata;
   logic [WIDTH-1:0]           cell_q   [DEPTH];
   logic [WIDTH-1:0]           cell_tap [DEPTH];
   logic [WIDTH-1:0]           tap_or;
   logic [63:0]                rd_wide;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_acc   = req_valid && !req_stall;

   // Resolve target positions and range checks
   assign ins_pos = req_data.at_end ? CMPW'(fill_ff) : CMPW'(req_data.index);
   assign rd_pos  = req_data.at_end ? CMPW'(fill_ff - CW'(1)) : CMPW'(req_data.index);
   assign ins_ok  = (fill_ff < CW'(DEPTH)) && (ins_pos <= CMPW'(fill_ff));
   assign rd_ok   = (fill_ff != '0) && (rd_pos < CMPW'(fill_ff));

   assign wdata = WIDTH'(64'(req_data.write_data));

   // Decode the operation into a cell command and the next count
   always_comb begin
      op_ok            = 1'b0;
      cell_ctrl        = '0;
      cell_pos         = PW'(rd_pos);
      fill_in          = fill_ff;
      case (req_data.func)
         isa_pkg::FUNC_READ: begin
            op_ok = rd_ok;
         end
         isa_pkg::FUNC_INSERT: begin
            op_ok            = ins_ok;
            cell_pos         = PW'(ins_pos);
            cell_ctrl.insert = req_acc && ins_ok;
            if (ins_ok) begin
               fill_in = fill_ff + CW'(1);
            end
         end
         isa_pkg::FUNC_ERASE, isa_pkg::FUNC_EXTRACT: begin
            op_ok            = rd_ok;
            cell_ctrl.remove = req_acc && rd_ok;
            if (rd_ok) begin
               fill_in = fill_ff - CW'(1);
            end
         end
         isa_pkg::FUNC_CLEAR: begin
            op_ok   = 1'b1;
            fill_in = '0;
         end
         default: begin
            op_ok = 1'b0;
         end
      endcase
   end

   // Row of cells, each handing its word to its neighbors
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WIDTH-1:0] left_w;
      logic [WIDTH-1:0] right_w;

      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = cell_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = cell_q[i+1];
      end

      isa_cell #(
         .WIDTH (WIDTH),
         .PW    (PW),
         .IDX   (i)
      ) u_cell (
         .clock    (clock),
         .ctrl     (cell_ctrl),
         .pos      (cell_pos),
         .wdata    (wdata),
         .left_in  (left_w),
         .right_in (right_w),
         .data_out (cell_q[i]),
         .tap_out  (cell_tap[i])
      );
   end

   // Merge the selected cell word
   always_comb begin
      tap_or = '0;
      for (int i = 0; i < DEPTH; i++) begin
         tap_or = tap_or | cell_tap[i];
      end
   end

   assign rd_wide = 64'(tap_or);

   // Build the result beat
   always_comb begin
      rsp_in.ok        = op_ok;
      rsp_in.read_data = '0;
      if (op_ok && (req_data.func == isa_pkg::FUNC_READ ||
                    req_data.func == isa_pkg::FUNC_EXTRACT)) begin
         rsp_in.read_data = rd_wide[isa_pkg::DataW-1:0];
      end
      rsp_in.count     = isa_pkg::CountW'(fill_in);
      rsp_in.empty_res = (fill_in == '0);
   end

   assign rsp_valid_in = req_acc || (rsp_valid_ff && rsp_stall);

   // Advance count and hold the response until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_acc) begin
            fill_ff <= fill_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ISA_ASSERT_NOW(a_fill_in_range, clock, reset, 1'b1, fill_ff <= CW'(DEPTH), "count above capacity")
   `ISA_ASSERT_NEXT(a_fail_keeps_count, clock, reset, req_acc && !op_ok, fill_ff == $past(fill_ff), "failed request changed count")
   `ISA_ASSERT_NOW(a_fail_zero_data, clock, reset, rsp_valid_ff && !rsp_ff.ok, rsp_ff.read_data == '0, "failed result carries data")

endmodule
